[hdl/rsa_pkg.sv]
// Shared types and constants for the reference-counted slot allocator.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package rsa_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int NUM_SLOTS_DEF  = 64;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed payload field widths
  localparam int SLOT_W   = 6;
  localparam int COUNT_OW = 16;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_REF   = 2'd1;
  localparam logic [1:0] OP_REL   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_NOTUSED = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // Request payload
  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot_id;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot_out;
    logic                freed;
    logic [COUNT_OW-1:0] count_out;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/rsa_count_mem.sv]
// Reference count store: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module rsa_count_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/rsa_slot_search.sv]
// Rotating first-free search over the per-slot free flags.
// No package dependencies.
`default_nettype none

module rsa_slot_search #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic [NUM_SLOTS-1:0]         free_vec,
  input  wire logic [$clog2(NUM_SLOTS)-1:0] start,
  output logic                              found,
  output logic      [$clog2(NUM_SLOTS)-1:0] idx
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  logic [NUM_SLOTS-1:0] upper;
  logic [IDX_W-1:0]     upper_idx;
  logic [IDX_W-1:0]     any_idx;

  // free slots at or above the start point
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      upper[i] = free_vec[i] && (IDX_W'(i) >= start);
    end
  end

  // lowest set bit of each vector
  always_comb begin
    upper_idx = '0;
    any_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (upper[i]) begin
        upper_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        any_idx = IDX_W'(i);
      end
    end
  end

  // prefer the upper part, otherwise wrap to the bottom
  assign found = |free_vec;
  assign idx   = (|upper) ? upper_idx : any_idx;

endmodule

`default_nettype wire

[hdl/refcounted_slot_allocator.sv]
// Reference-counted slot allocator, top level: sequencer, in-use flags, response register.
// Depends on rsa_pkg, rsa_count_mem and rsa_slot_search.
//
// Usage:
//   Requests arrive on req/req_valid/req_ready, responses leave on
//   rsp/rsp_valid/rsp_ready. Every request gives exactly one response,
//   in order.
//   A request is captured on acceptance; the sequencer then enters its
//   execute state and registers the response once the response register is free.
//   Each request passes through the count memory read (registered)
//   followed by the modify/write-back step, and no new request is taken
//   until that step has completed.
//   Allocate uses a combinational rotating search over the in-use flags,
//   starting after the slot handed out last.
//   If the response register is still full the sequencer holds in its
//   execute cycle and takes no new request until the register frees.
//   Reset clears the in-use flags and last-given pointer at once; a slot
//   whose flag is clear reads as count zero, so the count memory needs
//   no clearing pass and the block is ready as soon as reset is released.
`default_nettype none

module refcounted_slot_allocator #(
  parameter int NUM_SLOTS  = rsa_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rsa_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_ready,
  output rsa_pkg::rsp_t      rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_ready
);

  import rsa_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                  state;
  logic [NUM_SLOTS-1:0]    in_use;
  logic [IDX_W-1:0]        last_given;
  logic [1:0]              op;
  logic [SLOT_W-1:0]       slot;
  logic [IDX_W-1:0]        slot_idx;
  logic                    in_store;

  logic                    accept;
  logic                    fire;
  logic [IDX_W+SLOT_W-1:0] req_ext;
  logic                    req_in_store;
  logic [COUNT_BITS-1:0]   rdata;
  logic [COUNT_BITS-1:0]   cnt;
  logic [IDX_W-1:0]        start;
  logic                    found;
  logic [IDX_W-1:0]        found_idx;
  logic [IDX_W+SLOT_W-1:0] found_ext;

  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [COUNT_BITS-1:0]   cnt_next;
  logic                    set_use;
  logic                    clr_use;
  logic                    take_last;
  rsa_pkg::rsp_t           rsp_next;
  logic [COUNT_BITS+COUNT_OW-1:0] cnt_ext;

  // request decode
  assign req_ready    = (state == S_IDLE);
  assign accept       = req_valid && req_ready;
  assign req_ext      = (IDX_W + SLOT_W)'(req.slot_id);
  assign req_in_store = 32'(req.slot_id) < 32'(NUM_SLOTS);

  rsa_count_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (COUNT_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cnt_next),
    .re    (accept),
    .raddr (req_ext[IDX_W-1:0]),
    .rdata (rdata)
  );

  // search starts one past the last slot handed out
  assign start = (last_given == IDX_W'(NUM_SLOTS - 1)) ? '0 : last_given + IDX_W'(1);

  rsa_slot_search #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_search (
    .free_vec (~in_use),
    .start    (start),
    .found    (found),
    .idx      (found_idx)
  );

  assign found_ext = (IDX_W + SLOT_W)'(found_idx);

  // a slot with a clear flag, or outside the store, counts as zero
  assign cnt = (in_store && in_use[slot_idx]) ? rdata : '0;

  // the execute cycle completes once the response register can take data
  assign fire = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  // modify step
  always_comb begin
    rsp_next.status    = ST_OK;
    rsp_next.slot_out  = slot;
    rsp_next.freed     = 1'b0;
    cnt_next           = cnt;
    waddr              = slot_idx;
    we                 = 1'b0;
    set_use            = 1'b0;
    clr_use            = 1'b0;
    take_last          = 1'b0;
    case (op)
      OP_ALLOC: begin
        if (found) begin
          rsp_next.slot_out = found_ext[SLOT_W-1:0];
          cnt_next          = COUNT_BITS'(1);
          waddr             = found_idx;
          we                = fire;
          set_use           = fire;
          take_last         = fire;
        end else begin
          rsp_next.status   = ST_NOFREE;
          rsp_next.slot_out = '0;
          cnt_next          = '0;
        end
      end
      OP_REF: begin
        if (cnt == '0) begin
          rsp_next.status = ST_NOTUSED;
        end else if (cnt == CMAX) begin
          rsp_next.status = ST_SAT;
        end else begin
          cnt_next = cnt + COUNT_BITS'(1);
          we       = fire;
        end
      end
      OP_REL: begin
        if (cnt == '0) begin
          rsp_next.status = ST_NOTUSED;
        end else begin
          cnt_next       = cnt - COUNT_BITS'(1);
          we             = fire;
          rsp_next.freed = (cnt == COUNT_BITS'(1));
          clr_use        = fire && (cnt == COUNT_BITS'(1));
        end
      end
      default: begin
        // no operation: report the current count
      end
    endcase
    cnt_ext            = (COUNT_BITS + COUNT_OW)'(cnt_next);
    rsp_next.count_out = cnt_ext[COUNT_OW-1:0];
  end

  // sequencer, flags and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_use     <= '0;
      last_given <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (set_use) begin
        in_use[waddr] <= 1'b1;
      end
      if (clr_use) begin
        in_use[waddr] <= 1'b0;
      end
      if (take_last) begin
        last_given <= found_idx;
      end

      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request capture and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req.op;
      slot     <= req.slot_id;
      slot_idx <= req_ext[IDX_W-1:0];
      in_store <= req_in_store;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[bench/slot_alloc_monitor.sv]
// Request/response monitor for the slot allocator: predicts each response and compares it.
// Depends on rsa_pkg for the payload types, operation and status codes.
`timescale 1ns / 1ps

module slot_alloc_monitor #(
  parameter int NUM_SLOTS  = rsa_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rsa_pkg::req_t req,
  input  logic          req_valid,
  input  logic          req_ready,
  input  rsa_pkg::rsp_t rsp,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  output int            fail_count,
  output int            pending,
  output int            n_checked,
  output int            n_nofree,
  output int            n_notused,
  output int            n_sat,
  output int            n_freed
);
  import rsa_pkg::*;

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int              QDEPTH    = 16;

  // Shadow of the block's state
  logic [31:0] slot_count [NUM_SLOTS];
  int          last_issued;

  // Ring of responses still owed by the block
  rsp_t        awaited_rsp [QDEPTH];
  int          q_head = 0;
  int          q_tail = 0;

  // Work out the response to one request and update the shadow state
  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    logic [31:0] cnt;
    int          pos;
    bit          found;
    bit          in_store;
    res      = '0;
    in_store = int'(r.slot_id) < NUM_SLOTS;
    cnt      = in_store ? slot_count[r.slot_id] : 32'd0;
    case (r.op)
      OP_ALLOC: begin
        pos   = (last_issued + 1) % NUM_SLOTS;
        found = 1'b0;
        for (int n = 0; n < NUM_SLOTS; n++) begin
          if (!found && slot_count[pos] == 0) begin
            found            = 1'b1;
            slot_count[pos]  = 32'd1;
            last_issued      = pos;
            res.status       = ST_OK;
            res.slot_out     = SLOT_W'(pos);
            res.count_out    = 16'd1;
          end
          pos = (pos + 1) % NUM_SLOTS;
        end
        if (!found) res.status = ST_NOFREE;
      end
      OP_REF, OP_REL: begin
        res.slot_out = r.slot_id;
        if (cnt == 0) begin
          res.status = ST_NOTUSED;
        end else if (r.op == OP_REF) begin
          if (64'(cnt) >= COUNT_MAX) begin
            res.status    = ST_SAT;
            res.count_out = cnt[15:0];
          end else begin
            cnt                    = cnt + 1;
            slot_count[r.slot_id]  = cnt;
            res.status             = ST_OK;
            res.count_out          = cnt[15:0];
          end
        end else begin
          cnt                    = cnt - 1;
          slot_count[r.slot_id]  = cnt;
          res.status             = ST_OK;
          res.freed              = (cnt == 0);
          res.count_out          = cnt[15:0];
        end
      end
      default: begin
        // spare op code does nothing but report the count
        res.status    = ST_OK;
        res.slot_out  = r.slot_id;
        res.count_out = cnt[15:0];
      end
    endcase
    return res;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    fail_count++;
  endtask

  // Responses are checked before requests are taken in, so a response at
  // the edge of an acceptance can never be matched against that request
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_count[i] = '0;
      last_issued = 0;
      q_head      = 0;
      q_tail      = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (q_tail == q_head) begin
          $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
          fail_count++;
        end else begin
          want = awaited_rsp[q_head % QDEPTH];
          q_head++;
          n_checked++;
          if (rsp.status !== want.status)
            report_field("status", want.status, rsp.status);
          if (rsp.slot_out !== want.slot_out)
            report_field("slot_out", want.slot_out, rsp.slot_out);
          if (rsp.freed !== want.freed)
            report_field("freed", want.freed, rsp.freed);
          if (rsp.count_out !== want.count_out)
            report_field("count_out", want.count_out, rsp.count_out);
          case (want.status)
            ST_NOFREE:  n_nofree++;
            ST_NOTUSED: n_notused++;
            ST_SAT:     n_sat++;
            default:    ;
          endcase
          if (want.freed) n_freed++;
        end
      end
      if (req_valid && req_ready) begin
        awaited_rsp[q_tail % QDEPTH] = apply_request(req);
        q_tail++;
      end
    end
    pending = q_tail - q_head;
  end

endmodule

[bench/refcounted_slot_allocator_tb.sv]
// Top of the slot allocator testbench: clock, reset, request stimulus and response stalls.
// Depends on rsa_pkg, refcounted_slot_allocator and slot_alloc_monitor.
`timescale 1ns / 1ps

module refcounted_slot_allocator_tb;
  import rsa_pkg::*;

  localparam int NUM_SLOTS    = NUM_SLOTS_DEF;
  localparam int COUNT_BITS   = COUNT_BITS_DEF;
  localparam int RANDOM_ITEMS = 1366;

  // Traffic mixes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_CHURN = 1;
  localparam int MIX_DRAIN = 2;
  localparam int MIX_EVEN  = 3;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  req_t req       = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_ready = 1'b0;

  int   fail_count, pending, n_checked, n_nofree, n_notused, n_sat, n_freed;
  int   n_sent     = 0;
  bit   quiet      = 1'b0;
  int   idle_pct   = 20;
  int   stall_left = 0;

  refcounted_slot_allocator #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  slot_alloc_monitor #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) monitor (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_nofree   (n_nofree),
    .n_notused  (n_notused),
    .n_sat      (n_sat),
    .n_freed    (n_freed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly short, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [1:0] pick_op(int mix);
    int r;
    int a_lim, f_lim, l_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin a_lim = 60; f_lim = 75; l_lim = 95; end
      MIX_CHURN: begin a_lim = 25; f_lim = 55; l_lim = 95; end
      MIX_DRAIN: begin a_lim = 5;  f_lim = 15; l_lim = 95; end
      default:   begin a_lim = 25; f_lim = 50; l_lim = 75; end
    endcase
    if (r < a_lim) return OP_ALLOC;
    if (r < f_lim) return OP_REF;
    if (r < l_lim) return OP_REL;
    return OP_NOP;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return SLOT_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Present one request, hold it until taken, then maybe idle
  task automatic send_req(input logic [1:0] op, input logic [SLOT_W-1:0] slot);
    int gap;
    req_valid <= 1'b1;
    req       <= '{op: op, slot_id: slot};
    do @(posedge clk); while (!req_ready);
    n_sent++;
    gap = (!quiet && $urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Response side stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (quiet) begin
      rsp_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = pick_gap() - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  initial begin
    int done;
    int burst;
    int mix;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Free slots at the ends of the range, then the spare op code
    send_req(OP_REF, '0);
    send_req(OP_REL, '1);
    send_req(OP_NOP, '0);
    send_req(OP_NOP, '1);
    // First allocate after reset starts one past slot 0; slot field is ignored
    send_req(OP_ALLOC, '1);
    send_req(OP_REF, SLOT_W'(1));
    send_req(OP_REL, SLOT_W'(1));
    send_req(OP_REL, SLOT_W'(1));
    // Fill every slot, wrapping through slot 0, then ask once more
    repeat (NUM_SLOTS) send_req(OP_ALLOC, pick_slot());
    send_req(OP_ALLOC, '0);
    // Free both ends and take them back in search order
    send_req(OP_REL, '0);
    send_req(OP_REL, '1);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_NOP, SLOT_W'(5));

    // Back-to-back updates of slot 0 with no stalls
    quiet = 1'b1;
    send_req(OP_REF, '0);
    send_req(OP_NOP, '0);
    send_req(OP_REL, '0);
    send_req(OP_REF, '0);
    send_req(OP_REF, '0);
    quiet = 1'b0;

    // Random bursts, each with its own traffic mix and idling level
    done = 0;
    while (done < RANDOM_ITEMS) begin
      mix      = $urandom_range(MIX_FILL, MIX_EVEN);
      quiet    = ($urandom_range(0, 4) == 0);
      idle_pct = $urandom_range(5, 45);
      burst    = $urandom_range(40, 160);
      if (burst > RANDOM_ITEMS - done) burst = RANDOM_ITEMS - done;
      repeat (burst) begin
        send_req(pick_op(mix), pick_slot());
        done++;
      end
    end
    req_valid <= 1'b0;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses", n_sent, n_checked);
    $display("Seen: %0d full-store allocates, %0d free-slot errors, %0d saturations, %0d frees",
             n_nofree, n_notused, n_sat, n_freed);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Timeout with %0d responses outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
hdl/rsa_pkg.sv
hdl/rsa_count_mem.sv
hdl/rsa_slot_search.sv
hdl/refcounted_slot_allocator.sv
bench/slot_alloc_monitor.sv
bench/refcounted_slot_allocator_tb.sv
